/* hdl/mfrp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfrp_pkg
// Shared types, codes and helpers of the message framing record parser.
// ----------------------------------------------------------------------------
package mfrp_pkg;

	// Default number of 7-bit groups allowed in a length field.
	localparam int LENGTH_GROUPS_MAX_DEF = 5;
	// Number of groups that can contribute bits to a 32-bit length.
	localparam logic [2:0] LENGTH_GROUP_SLOTS = 3'd5;
	// Reset value of the envelope size limit.
	localparam logic [31:0] MAX_ENVELOPE_RESET = 32'd65536;
	// Depth of the result queue.
	localparam int RESULT_DEPTH = 4;

	// Record type codes.
	localparam logic [3:0] TYPE_VERSION       = 4'd0;
	localparam logic [3:0] TYPE_MODE          = 4'd1;
	localparam logic [3:0] TYPE_VIA           = 4'd2;
	localparam logic [3:0] TYPE_KNOWN_ENC     = 4'd3;
	localparam logic [3:0] TYPE_EXT_ENC       = 4'd4;
	localparam logic [3:0] TYPE_UNSIZED_ENV   = 4'd5;
	localparam logic [3:0] TYPE_SIZED_ENV     = 4'd6;
	localparam logic [3:0] TYPE_FAULT         = 4'd8;
	localparam logic [3:0] TYPE_UPGRADE_REQ   = 4'd9;
	localparam logic [7:0] TYPE_LAST          = 8'h0C;

	// Accepted value ranges of Mode and KnownEncoding.
	localparam logic [7:0] MODE_MIN = 8'd1;
	localparam logic [7:0] MODE_MAX = 8'd4;
	localparam logic [7:0] ENC_MAX  = 8'd8;

	// Result status codes.
	localparam logic [2:0] ST_RECORD   = 3'd0;
	localparam logic [2:0] ST_INVALID  = 3'd1;
	localparam logic [2:0] ST_STOP     = 3'd2;
	localparam logic [2:0] ST_TRAILING = 3'd3;
	localparam logic [2:0] ST_SUMMARY  = 3'd4;

	// One result item.
	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  record_kind;
		logic [31:0] record_bytes;
		logic [7:0]  value_first;
		logic [7:0]  value_second;
		logic [31:0] payload_length;
		logic [31:0] trailing_offset;
		logic [31:0] parsed_count;
		logic        last_result;
	} result_t;

	// Saturating 32-bit add.
	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage
`default_nettype wire

/* hdl/message_framing_record_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// message_framing_record_parser
// Parses framing records from a byte stream, one byte per transfer, and
// reports records, stops and a frame summary.
//
//   Channel   Signals                              Direction
//   input     in_valid/in_ready, data_byte,        in
//             may_start, last_byte
//   output    out_valid/out_ready, status ...      out
//             last_result
//   config    cfg_write_en, cfg_write_data         in
//
// A byte enters an input register, is parsed there, and its results go
// into a four-entry result queue; one byte per cycle is sustained while
// the queue has room for two results. A last byte can give two results.
// Input is taken whenever the queue has room for two results.
// Reset clears all parse state and sets the envelope limit to 65536.
// ----------------------------------------------------------------------------
module message_framing_record_parser #(
	parameter int LENGTH_GROUPS_MAX = mfrp_pkg::LENGTH_GROUPS_MAX_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          in_valid,
	output logic         in_ready,
	input  wire  [7:0]   data_byte,
	input  wire          may_start,
	input  wire          last_byte,
	output logic         out_valid,
	input  wire          out_ready,
	output logic [2:0]   status,
	output logic [3:0]   record_kind,
	output logic [31:0]  record_bytes,
	output logic [7:0]   value_first,
	output logic [7:0]   value_second,
	output logic [31:0]  payload_length,
	output logic [31:0]  trailing_offset,
	output logic [31:0]  parsed_count,
	output logic         last_result,
	input  wire          cfg_write_en,
	input  wire  [31:0]  cfg_write_data
);

	typedef enum logic [6:0] {
		PH_IDLE      = 7'b0000001,
		PH_VER_MAJOR = 7'b0000010,
		PH_VER_MINOR = 7'b0000100,
		PH_MODE      = 7'b0001000,
		PH_ENC       = 7'b0010000,
		PH_LEN       = 7'b0100000,
		PH_PAYLOAD   = 7'b1000000
	} phase_t;

	// Input register.
	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         start_s1;
	logic         last_s1;

	// Parse state.
	phase_t       phase_q;
	logic [3:0]   type_q;
	logic [31:0]  acc_q;
	logic [2:0]   grp_q;
	logic [31:0]  rem_q;
	logic [31:0]  rbytes_q;
	logic [31:0]  pos_q;
	logic [31:0]  size_q;
	logic [7:0]   first_q;
	logic         stopped_q;
	logic         trail_seen_q;
	logic [31:0]  trail_start_q;
	logic [31:0]  max_env_q;

	// Next state.
	phase_t       n_phase;
	logic [3:0]   n_type;
	logic [31:0]  n_acc;
	logic [2:0]   n_grp;
	logic [31:0]  n_rem;
	logic [31:0]  n_rbytes;
	logic [31:0]  n_pos;
	logic [31:0]  n_size;
	logic [7:0]   n_first;
	logic         n_stopped;
	logic         n_trail_seen;
	logic [31:0]  n_trail_start;

	// Helpers.
	logic               advance;
	logic               room_two;
	logic [31:0]        pos_inc;
	logic [31:0]        rbytes_inc;
	logic [5:0]         shamt;
	logic [38:0]        grp_val;
	logic               rec_fire;
	logic               main_fire;
	mfrp_pkg::result_t  main_res;
	mfrp_pkg::result_t  sum_res;
	mfrp_pkg::result_t  push_a;
	mfrp_pkg::result_t  head;

	// The input register frees whenever its byte moves on.
	assign advance  = valid_s1 && room_two;
	assign in_ready = !valid_s1 || room_two;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= data_byte;
			start_s1 <= may_start;
			last_s1  <= last_byte;
		end
	end

	// Envelope size limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_env_q <= mfrp_pkg::MAX_ENVELOPE_RESET;
		end else if (cfg_write_en) begin
			max_env_q <= cfg_write_data;
		end
	end

	assign pos_inc    = mfrp_pkg::sat_add(pos_q, 32'd1);
	assign rbytes_inc = mfrp_pkg::sat_add(rbytes_q, 32'd1);
	assign shamt      = 6'(grp_q) * 6'd7;
	assign grp_val    = 39'(byte_s1[6:0]) << shamt;

	// One parse step for the byte in the input register.
	always_comb begin
		n_phase       = phase_q;
		n_type        = type_q;
		n_acc         = acc_q;
		n_grp         = grp_q;
		n_rem         = rem_q;
		n_rbytes      = rbytes_q;
		n_pos         = pos_q;
		n_size        = size_q;
		n_first       = first_q;
		n_stopped     = stopped_q;
		n_trail_seen  = trail_seen_q;
		n_trail_start = trail_start_q;
		rec_fire      = 1'b0;
		main_fire     = 1'b0;
		main_res      = '0;
		sum_res       = '0;

		if (!stopped_q) begin
			case (phase_q)
				PH_IDLE: begin
					if (!start_s1) begin
						n_stopped = 1'b1;
					end else if (byte_s1 > mfrp_pkg::TYPE_LAST) begin
						main_fire             = 1'b1;
						main_res.status       = mfrp_pkg::ST_INVALID;
						main_res.record_bytes = 32'd1;
						main_res.value_first  = byte_s1;
						n_stopped             = 1'b1;
					end else begin
						n_type   = byte_s1[3:0];
						n_rbytes = 32'd1;
						n_first  = '0;
						n_acc    = '0;
						n_grp    = '0;
						n_rem    = '0;
						case (byte_s1[3:0])
							mfrp_pkg::TYPE_VERSION:   n_phase = PH_VER_MAJOR;
							mfrp_pkg::TYPE_MODE:      n_phase = PH_MODE;
							mfrp_pkg::TYPE_KNOWN_ENC: n_phase = PH_ENC;
							mfrp_pkg::TYPE_VIA, mfrp_pkg::TYPE_SIZED_ENV,
							mfrp_pkg::TYPE_FAULT, mfrp_pkg::TYPE_UPGRADE_REQ:
								n_phase = PH_LEN;
							mfrp_pkg::TYPE_EXT_ENC, mfrp_pkg::TYPE_UNSIZED_ENV: begin
							end
							default: begin
								rec_fire              = 1'b1;
								main_res.record_kind  = byte_s1[3:0];
								main_res.record_bytes = 32'd1;
							end
						endcase
					end
				end
				PH_VER_MAJOR: begin
					n_first  = byte_s1;
					n_rbytes = 32'd2;
					n_phase  = PH_VER_MINOR;
				end
				PH_VER_MINOR: begin
					rec_fire              = 1'b1;
					main_res.record_kind  = mfrp_pkg::TYPE_VERSION;
					main_res.record_bytes = 32'd3;
					main_res.value_first  = first_q;
					main_res.value_second = byte_s1;
				end
				PH_MODE: begin
					n_phase = PH_IDLE;
					if (byte_s1 inside {[mfrp_pkg::MODE_MIN:mfrp_pkg::MODE_MAX]}) begin
						rec_fire              = 1'b1;
						main_res.record_kind  = mfrp_pkg::TYPE_MODE;
						main_res.record_bytes = 32'd2;
						main_res.value_first  = byte_s1;
					end
				end
				PH_ENC: begin
					n_phase = PH_IDLE;
					if (byte_s1 <= mfrp_pkg::ENC_MAX) begin
						rec_fire              = 1'b1;
						main_res.record_kind  = mfrp_pkg::TYPE_KNOWN_ENC;
						main_res.record_bytes = 32'd2;
						main_res.value_first  = byte_s1;
					end
				end
				PH_LEN: begin
					if (grp_q < mfrp_pkg::LENGTH_GROUP_SLOTS) begin
						n_acc = acc_q | grp_val[31:0];
					end
					n_grp    = grp_q + 3'd1;
					n_rbytes = rbytes_inc;
					if (({1'b0, grp_q} + 4'd1) >= 4'(LENGTH_GROUPS_MAX) || !byte_s1[7]) begin
						if (n_acc == '0) begin
							if (type_q == mfrp_pkg::TYPE_SIZED_ENV) begin
								rec_fire              = 1'b1;
								main_res.record_kind  = type_q;
								main_res.record_bytes = n_rbytes;
							end else begin
								main_fire             = 1'b1;
								main_res.status       = mfrp_pkg::ST_STOP;
								main_res.record_kind  = type_q;
								main_res.record_bytes = n_rbytes;
								n_stopped             = 1'b1;
							end
						end else begin
							n_rem         = n_acc;
							n_trail_start = pos_inc;
							n_phase       = PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					n_rbytes = rbytes_inc;
					if (rem_q != '0) begin
						n_rem = rem_q - 32'd1;
					end
					if (n_rem == '0) begin
						rec_fire                = 1'b1;
						main_res.record_kind    = type_q;
						main_res.record_bytes   = n_rbytes;
						main_res.payload_length = acc_q;
					end
				end
				default: n_phase = PH_IDLE;
			endcase

			// A finished record returns to idle and adds to the size sum.
			if (rec_fire) begin
				main_fire = 1'b1;
				n_phase   = PH_IDLE;
				n_size    = mfrp_pkg::sat_add(size_q, main_res.record_bytes);
			end

			// Frame end inside a record.
			if (last_s1 && !n_stopped && n_phase != PH_IDLE) begin
				main_fire               = 1'b1;
				main_res                = '0;
				main_res.record_kind    = n_type;
				main_res.record_bytes   = n_rbytes;
				main_res.payload_length = n_acc;
				if ((n_phase == PH_LEN || n_phase == PH_PAYLOAD) &&
				    n_type == mfrp_pkg::TYPE_SIZED_ENV && n_acc > max_env_q) begin
					n_trail_seen             = 1'b1;
					n_trail_start            = (n_phase == PH_LEN) ? pos_inc : n_trail_start;
					main_res.status          = mfrp_pkg::ST_TRAILING;
					main_res.trailing_offset = n_trail_start;
				end else begin
					main_res.status      = mfrp_pkg::ST_STOP;
					main_res.value_first = n_first;
				end
				n_stopped = 1'b1;
			end
		end

		main_res.last_result = !last_s1;

		// Frame summary, then all parse state returns to reset values.
		sum_res.status          = mfrp_pkg::ST_SUMMARY;
		sum_res.trailing_offset = n_trail_seen ? n_trail_start : 32'd0;
		sum_res.parsed_count    = n_trail_seen ? n_trail_start : n_size;
		sum_res.last_result     = 1'b1;

		if (last_s1) begin
			n_phase       = PH_IDLE;
			n_type        = '0;
			n_acc         = '0;
			n_grp         = '0;
			n_rem         = '0;
			n_rbytes      = '0;
			n_pos         = '0;
			n_size        = '0;
			n_first       = '0;
			n_stopped     = 1'b0;
			n_trail_seen  = 1'b0;
			n_trail_start = '0;
		end else begin
			n_pos = pos_inc;
		end
	end

	// Parse state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			type_q        <= '0;
			acc_q         <= '0;
			grp_q         <= '0;
			rem_q         <= '0;
			rbytes_q      <= '0;
			pos_q         <= '0;
			size_q        <= '0;
			first_q       <= '0;
			stopped_q     <= 1'b0;
			trail_seen_q  <= 1'b0;
			trail_start_q <= '0;
		end else if (advance) begin
			phase_q       <= n_phase;
			type_q        <= n_type;
			acc_q         <= n_acc;
			grp_q         <= n_grp;
			rem_q         <= n_rem;
			rbytes_q      <= n_rbytes;
			pos_q         <= n_pos;
			size_q        <= n_size;
			first_q       <= n_first;
			stopped_q     <= n_stopped;
			trail_seen_q  <= n_trail_seen;
			trail_start_q <= n_trail_start;
		end
	end

	// Results go in order: record, stop, invalid or trailing first, then the summary.
	assign push_a = main_fire ? main_res : sum_res;

	mfrp_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_one  (advance && (main_fire || last_s1)),
		.push_two  (advance && main_fire && last_s1),
		.data_one  (push_a),
		.data_two  (sum_res),
		.room_two  (room_two),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign status          = head.status;
	assign record_kind     = head.record_kind;
	assign record_bytes    = head.record_bytes;
	assign value_first     = head.value_first;
	assign value_second    = head.value_second;
	assign payload_length  = head.payload_length;
	assign trailing_offset = head.trailing_offset;
	assign parsed_count    = head.parsed_count;
	assign last_result     = head.last_result;

	// After the last byte of a frame, parsing starts over.
	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> phase_q == PH_IDLE && !stopped_q && pos_q == '0)
		else $error("state not cleared after frame end");

	// Trailing data is only reported together with a stop.
	a_trail_stop: assert property (@(posedge clk) disable iff (!arst_n)
		trail_seen_q |-> stopped_q)
		else $error("trailing data without stop");

	// The byte position moves only when a byte is parsed.
	a_pos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(pos_q))
		else $error("byte position moved without a transfer");

endmodule
`default_nettype wire

/* hdl/mfrp_result_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfrp_result_fifo
// Small result queue that takes up to two results per cycle and hands out
// one per transfer. Reports room for two more entries.
// ----------------------------------------------------------------------------
module mfrp_result_fifo (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     push_one,
	input  wire                     push_two,
	input  wire mfrp_pkg::result_t  data_one,
	input  wire mfrp_pkg::result_t  data_two,
	output logic                    room_two,
	output logic                    out_valid,
	input  wire                     out_ready,
	output mfrp_pkg::result_t       head
);

	localparam int PW = $clog2(mfrp_pkg::RESULT_DEPTH);
	localparam int CW = PW + 1;

	mfrp_pkg::result_t       mem_q [mfrp_pkg::RESULT_DEPTH];
	logic [PW-1:0]           wr_ptr_q;
	logic [PW-1:0]           rd_ptr_q;
	logic [CW-1:0]           count_q;
	logic                    pop;
	logic [CW-1:0]           n_push;

	// Handshake and occupancy.
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign head      = mem_q[rd_ptr_q];
	assign room_two  = (count_q <= CW'(mfrp_pkg::RESULT_DEPTH - 2));
	assign n_push    = push_two ? CW'(2) : (push_one ? CW'(1) : CW'(0));

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push_one) begin
			mem_q[wr_ptr_q] <= data_one;
		end
		if (push_two) begin
			mem_q[wr_ptr_q + PW'(1)] <= data_two;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + n_push - (pop ? CW'(1) : CW'(0));
		end
	end

	// The queue never overfills.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(mfrp_pkg::RESULT_DEPTH))
		else $error("result queue overfilled");

	// A second entry is written only with a first one.
	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		push_two |-> push_one)
		else $error("second result pushed without a first");

endmodule
`default_nettype wire
